// ===== sv/cdsd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdsd_pkg
// Shared types, codes and lookup functions for the clock digit scan driver.
// ----------------------------------------------------------------------------
package cdsd_pkg;

  localparam int unsigned DIGIT_COUNT = 6;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned TICK_W      = 16;

  typedef logic [7:0]        byte_t;
  typedef logic [3:0]        nibble_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [TICK_W-1:0] tick_t;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_BUTTON = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_TIME  = 2'd0,
    MODE_DATE  = 2'd1,
    MODE_YEAR  = 2'd2,
    MODE_BLANK = 2'd3
  } mode_t;

  localparam byte_t   BLANK_CODE   = 8'hFF;
  localparam byte_t   DOT_BIT      = 8'h40;
  localparam tick_t   TICK_MAX     = 16'hFFFF;
  localparam tick_t   BLINK_RESET  = 16'd512;
  localparam pos_t    POS_LAST     = pos_t'(DIGIT_COUNT - 1);

  // digit select bits for each scan position
  function automatic byte_t select_bits(input pos_t pos);
    byte_t sel;
    unique case (pos)
      3'd0:    sel = 8'h00;
      3'd1:    sel = 8'h80;
      3'd2:    sel = 8'h09;
      3'd3:    sel = 8'h01;
      3'd4:    sel = 8'h88;
      3'd5:    sel = 8'h08;
      default: sel = 8'h00;
    endcase
    return sel;
  endfunction

  // number pattern; nibbles above nine show as zero
  function automatic byte_t digit_pattern(input nibble_t nib);
    byte_t pat;
    unique case (nib)
      4'd0:    pat = 8'h00;
      4'd1:    pat = 8'h20;
      4'd2:    pat = 8'h02;
      4'd3:    pat = 8'h22;
      4'd4:    pat = 8'h04;
      4'd5:    pat = 8'h24;
      4'd6:    pat = 8'h06;
      4'd7:    pat = 8'h26;
      4'd8:    pat = 8'h10;
      4'd9:    pat = 8'h30;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// ===== sv/clock_digit_scan_display_driver.sv =====
// ----------------------------------------------------------------------------
// clock_digit_scan_display_driver
// Scans a six-digit clock display one digit per tick, with a mode button.
// ----------------------------------------------------------------------------
// structure: input register, then result register after one level of lookup and
//   counter logic
// throughput: one transaction per cycle while out_stall is low, set by the single result register
// reset: synchronous active-low; mode, digit position, tick count and last
//   seconds clear to zero, blink_ticks returns to 512, both stages empty
module clock_digit_scan_display_driver (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_blink_ticks,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [7:0]            in_seconds_bcd,
  input  logic [7:0]            in_minutes_bcd,
  input  logic [7:0]            in_hours_bcd,
  input  logic [2:0]            in_weekday,
  input  logic [7:0]            in_date_bcd,
  input  logic [7:0]            in_month_bcd,
  input  logic [7:0]            in_year_bcd,
  input  logic [7:0]            in_century_bcd,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_segment_code,
  output logic                  out_weekday_update,
  output logic [7:0]            out_weekday_leds
);

  import cdsd_pkg::*;

  // input register
  logic  in_valid_r;
  cmd_t  cmd_r;
  byte_t sec_r, min_r, hour_r, date_r, month_r, year_r, cent_r;
  logic [2:0] wday_r;

  // block state
  tick_t blink_r;
  mode_t mode_r, mode_nxt;
  pos_t  pos_r, pos_nxt;
  tick_t ticks_r, ticks_nxt;
  byte_t prev_sec_r;

  // result register
  logic  out_valid_r;
  byte_t code_r, code_nxt;
  logic  upd_r, upd_nxt;
  byte_t leds_r, leds_nxt;

  logic  out_free;
  logic  advance;
  logic  in_take;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_r <= BLINK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      blink_r <= cfg_blink_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r   <= cmd_t'(in_command);
      sec_r   <= in_seconds_bcd;
      min_r   <= in_minutes_bcd;
      hour_r  <= in_hours_bcd;
      wday_r  <= in_weekday;
      date_r  <= in_date_bcd;
      month_r <= in_month_bcd;
      year_r  <= in_year_bcd;
      cent_r  <= in_century_bcd;
    end
  end

  // per-item logic
  logic  dot;
  logic  show;
  logic  use_high;
  logic  lit_dot;
  byte_t src;
  nibble_t nib;

  always_comb begin
    pos_nxt = (pos_r >= POS_LAST) ? '0 : pos_r + pos_t'(1);
    if (sec_r == prev_sec_r) begin
      ticks_nxt = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + tick_t'(1);
    end else begin
      ticks_nxt = '0;
    end
    mode_nxt = mode_t'(mode_r + 2'd1);
    dot      = ticks_nxt < blink_r;
  end

  // pick which byte and nibble this position shows
  always_comb begin
    show     = 1'b1;
    src      = sec_r;
    use_high = pos_nxt[0];
    lit_dot  = 1'b0;
    unique case (mode_r)
      MODE_TIME: begin
        unique case (pos_nxt)
          3'd0, 3'd1: src = sec_r;
          3'd2, 3'd3: src = min_r;
          default:    src = hour_r;
        endcase
        lit_dot = dot && (pos_nxt == 3'd2 || pos_nxt == 3'd4);
      end
      MODE_DATE: begin
        unique case (pos_nxt)
          3'd0: begin src = date_r;  use_high = 1'b0; end
          3'd1: begin src = date_r;  use_high = 1'b1; end
          3'd3: begin src = month_r; use_high = 1'b0; end
          3'd4: begin src = month_r; use_high = 1'b1; end
          default: show = 1'b0;
        endcase
      end
      MODE_YEAR: begin
        unique case (pos_nxt)
          3'd1: begin src = year_r; use_high = 1'b0; end
          3'd2: begin src = year_r; use_high = 1'b1; end
          3'd3: begin src = cent_r; use_high = 1'b0; end
          3'd4: begin src = cent_r; use_high = 1'b1; end
          default: show = 1'b0;
        endcase
      end
      default: show = 1'b0;
    endcase
    nib = use_high ? src[7:4] : src[3:0];
  end

  always_comb begin
    if (cmd_r == CMD_BUTTON) begin
      code_nxt = BLANK_CODE;
      upd_nxt  = 1'b0;
      leds_nxt = '0;
    end else begin
      code_nxt = show ? (select_bits(pos_nxt) | digit_pattern(nib) |
                         (lit_dot ? DOT_BIT : 8'h00))
                      : BLANK_CODE;
      upd_nxt  = 1'b1;
      leds_nxt = (wday_r == 3'd0) ? 8'h00 : byte_t'(8'h01 << (wday_r - 3'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_TIME;
      pos_r      <= '0;
      ticks_r    <= '0;
      prev_sec_r <= '0;
    end else if (advance) begin
      if (cmd_r == CMD_BUTTON) begin
        mode_r <= mode_nxt;
      end else begin
        pos_r      <= pos_nxt;
        ticks_r    <= ticks_nxt;
        prev_sec_r <= sec_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      code_r <= code_nxt;
      upd_r  <= upd_nxt;
      leds_r <= leds_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_segment_code   = code_r;
  assign out_weekday_update = upd_r;
  assign out_weekday_leds   = leds_r;

  // scan position never leaves the six digits
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("digit position out of range");

  // a button transaction advances the mode and nothing else
  a_button_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cmd_r == CMD_BUTTON) |=>
      (mode_r == mode_t'($past(mode_r) + 2'd1)) && $stable(pos_r) && $stable(ticks_r))
    else $error("button press did not advance mode alone");

  // a tick on the same second counts up unless saturated
  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cmd_r == CMD_TICK && sec_r == prev_sec_r && ticks_r != TICK_MAX) |=>
      ticks_r == $past(ticks_r) + tick_t'(1))
    else $error("tick count did not advance");

  // a button result is always blank with no weekday lamps
  a_button_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !upd_r) |-> (code_r == BLANK_CODE && leds_r == 8'h00))
    else $error("button result not blank");

  // input side only stalls while holding an item the result side cannot take
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("input stalled without cause");

endmodule
